// ===== sv/keypad_combination_lock_assert.svh =====
// Assertion macros for the lock's checker file
`ifndef KEYPAD_COMBINATION_LOCK_ASSERT_SVH
`define KEYPAD_COMBINATION_LOCK_ASSERT_SVH

// Same-cycle implication, held off during reset
`define KCL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kcl assertion failed");

// Next-cycle implication, held off during reset
`define KCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kcl assertion failed");

`endif

// ===== sv/kcl_pkg.sv =====
package kcl_pkg;

  // Code store geometry
  localparam int CODE_LENGTH = 10;
  localparam int KEY_W       = 4;
  localparam int CNT_W       = $clog2(CODE_LENGTH + 1);

  // Largest key value that counts as a digit
  localparam logic [KEY_W-1:0] KEY_MAX = 4'd9;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_LOW  = 3'd3;

  localparam logic [15:0] OPEN_LIMIT_RST = 16'd15000;
  localparam logic [7:0]  MISS_THR_RST   = 8'd15;
  localparam logic [15:0] ALARM_HIGH_RST = 16'd500;
  localparam logic [15:0] ALARM_LOW_RST  = 16'd300;

  // Input item kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_SCAN    = 2'd1;
  localparam logic [1:0] KIND_CONFIRM = 2'd2;

  // Reported mode
  localparam logic [1:0] MODE_ENROLL = 2'd0;
  localparam logic [1:0] MODE_REPEAT = 2'd1;
  localparam logic [1:0] MODE_ENTER  = 2'd2;
  localparam logic [1:0] MODE_OPEN   = 2'd3;

  // Reported events
  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_DIGIT        = 4'd1,
    EV_FIRST_ENROLL = 4'd2,
    EV_REGISTERED   = 4'd3,
    EV_REPEAT_MISS  = 4'd4,
    EV_UNLOCKED     = 4'd5,
    EV_WRONG        = 4'd6,
    EV_ALARM        = 4'd7,
    EV_LOCKED       = 4'd8,
    EV_TIMEOUT      = 4'd9
  } kcl_event_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] key;
  } kcl_in_t;

  typedef struct packed {
    logic       lock_release;
    logic       alarm_pin;
    logic       alarm_on;
    logic [1:0] mode;
    logic [3:0] entered_len;
    logic [7:0] misses;
    logic [3:0] event_res;
  } kcl_out_t;

endpackage

// ===== sv/keypad_combination_lock.sv =====
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_stall   | kcl_in_t  (kind, key)
// out_    | output    | out_valid / out_stall | kcl_out_t (one result per item)
// cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// Each item is registered on transfer, then processed against the lock state
// and written to the output register; one item per cycle is sustained while
// out_ is not stalled, set by the single compare-and-update pass.
// Synchronous active-low reset restores the valid flags, lock state and config defaults.
// A stall on out_ holds the result; the input register then holds and
// in_stall rises, so items wait upstream without loss.
module keypad_combination_lock
  import kcl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  kcl_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output kcl_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [15:0] open_limit_r;
  logic [7:0]  miss_thr_r;
  logic [15:0] alarm_high_r;
  logic [15:0] alarm_low_r;

  // Pipeline registers
  logic     in_valid_r;
  kcl_in_t  in_data_r;
  logic     out_valid_r;
  kcl_out_t out_data_r;
  logic     adv;

  // Lock state
  logic [KEY_W-1:0] stored_r   [CODE_LENGTH];
  logic [KEY_W-1:0] entry_r    [CODE_LENGTH];
  logic [KEY_W-1:0] stored_nxt [CODE_LENGTH];
  logic [KEY_W-1:0] entry_nxt  [CODE_LENGTH];
  logic [CNT_W-1:0] entry_cnt_r, entry_cnt_nxt;
  logic             registered_r, registered_nxt;
  logic             door_r, door_nxt;
  logic [15:0]      open_timer_r, open_timer_nxt;
  logic [7:0]       miss_r, miss_nxt;
  logic             alarm_r, alarm_nxt;
  logic             level_r, level_nxt;
  logic [15:0]      blink_r, blink_nxt;
  logic [KEY_W-1:0] prev_key_r, prev_key_nxt;
  kcl_out_t         res_nxt;

  // Configuration writes; unlisted indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_limit_r <= OPEN_LIMIT_RST;
      miss_thr_r   <= MISS_THR_RST;
      alarm_high_r <= ALARM_HIGH_RST;
      alarm_low_r  <= ALARM_LOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OPEN_LIMIT: open_limit_r <= cfg_wdata;
        CFG_MISS_THR:   miss_thr_r   <= cfg_wdata[7:0];
        CFG_ALARM_HIGH: alarm_high_r <= cfg_wdata;
        CFG_ALARM_LOW:  alarm_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: process when the output register is free or draining
  assign adv       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res_nxt;
    end
  end

  // Next state and result for the item in the input register
  always_comb begin
    logic [KEY_W-1:0] key;
    logic [16:0]      open_inc;
    logic [16:0]      blink_inc;
    logic [15:0]      blink_lim;
    logic [7:0]       miss_inc;
    logic             match;
    kcl_event_t       ev;

    stored_nxt     = stored_r;
    entry_nxt      = entry_r;
    entry_cnt_nxt  = entry_cnt_r;
    registered_nxt = registered_r;
    door_nxt       = door_r;
    open_timer_nxt = open_timer_r;
    miss_nxt       = miss_r;
    alarm_nxt      = alarm_r;
    level_nxt      = level_r;
    blink_nxt      = blink_r;
    prev_key_nxt   = prev_key_r;
    ev             = EV_NONE;

    // Keys above nine read as no key
    key = (in_data_r.key > KEY_MAX) ? '0 : in_data_r.key;

    open_inc  = {1'b0, open_timer_r} + 17'd1;
    blink_inc = {1'b0, blink_r} + 17'd1;
    blink_lim = level_r ? alarm_high_r : alarm_low_r;
    miss_inc  = (miss_r != 8'hFF) ? miss_r + 8'd1 : miss_r;

    // Parallel compare of all positions
    match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (stored_r[i] != entry_r[i]) match = 1'b0;
    end

    unique case (in_data_r.kind)
      KIND_TICK: begin
        if (door_r) begin
          if (open_inc > {1'b0, open_limit_r}) begin
            door_nxt       = 1'b0;
            open_timer_nxt = '0;
            ev             = EV_TIMEOUT;
          end else begin
            open_timer_nxt = open_inc[15:0];
          end
        end
        // Blink timer runs on every tick, saturating
        if (alarm_r && blink_inc > {1'b0, blink_lim}) begin
          level_nxt = !level_r;
          blink_nxt = '0;
        end else begin
          blink_nxt = blink_inc[16] ? 16'hFFFF : blink_inc[15:0];
        end
      end

      KIND_SCAN: begin
        if (key != prev_key_r) begin
          if (key == '0 || door_r) begin
            prev_key_nxt = '0;
          end else begin
            if (entry_cnt_r < CNT_W'(CODE_LENGTH)) begin
              for (int i = 0; i < CODE_LENGTH; i++) begin
                if (CNT_W'(i) == entry_cnt_r) entry_nxt[i] = key;
              end
              entry_cnt_nxt = entry_cnt_r + CNT_W'(1);
              ev            = EV_DIGIT;
            end
            prev_key_nxt = key;
          end
        end
      end

      KIND_CONFIRM: begin
        if (door_r) begin
          door_nxt       = 1'b0;
          open_timer_nxt = '0;
          ev             = EV_LOCKED;
        end else begin
          if (!registered_r) begin
            if (stored_r[0] == '0) begin
              // first enrolment copies the digits entered
              for (int i = 0; i < CODE_LENGTH; i++) begin
                if (CNT_W'(i) < entry_cnt_r) stored_nxt[i] = entry_r[i];
              end
              ev = EV_FIRST_ENROLL;
            end else if (match) begin
              registered_nxt = 1'b1;
              ev             = EV_REGISTERED;
            end else begin
              ev = EV_REPEAT_MISS;
            end
          end else if (match) begin
            door_nxt       = 1'b1;
            open_timer_nxt = '0;
            miss_nxt       = '0;
            alarm_nxt      = 1'b0;
            level_nxt      = 1'b0;
            ev             = EV_UNLOCKED;
          end else begin
            miss_nxt = miss_inc;
            if (miss_inc >= miss_thr_r) begin
              alarm_nxt = 1'b1;
              ev        = EV_ALARM;
            end else begin
              ev = EV_WRONG;
            end
          end
          // entry is cleared after every closed-door confirm
          for (int i = 0; i < CODE_LENGTH; i++) begin
            entry_nxt[i] = '0;
          end
          entry_cnt_nxt = '0;
        end
      end

      default: ;
    endcase

    // Result from the updated state
    res_nxt.lock_release = door_nxt;
    res_nxt.alarm_pin    = level_nxt;
    res_nxt.alarm_on     = alarm_nxt;
    if (!registered_nxt) begin
      res_nxt.mode = (stored_nxt[0] == '0) ? MODE_ENROLL : MODE_REPEAT;
    end else begin
      res_nxt.mode = door_nxt ? MODE_OPEN : MODE_ENTER;
    end
    res_nxt.entered_len = 4'(entry_cnt_nxt);
    res_nxt.misses      = miss_nxt;
    res_nxt.event_res   = ev;
  end

  // State update on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        stored_r[i] <= '0;
        entry_r[i]  <= '0;
      end
      entry_cnt_r  <= '0;
      registered_r <= 1'b0;
      door_r       <= 1'b0;
      open_timer_r <= '0;
      miss_r       <= '0;
      alarm_r      <= 1'b0;
      level_r      <= 1'b0;
      blink_r      <= '0;
      prev_key_r   <= '0;
    end else if (adv) begin
      stored_r     <= stored_nxt;
      entry_r      <= entry_nxt;
      entry_cnt_r  <= entry_cnt_nxt;
      registered_r <= registered_nxt;
      door_r       <= door_nxt;
      open_timer_r <= open_timer_nxt;
      miss_r       <= miss_nxt;
      alarm_r      <= alarm_nxt;
      level_r      <= level_nxt;
      blink_r      <= blink_nxt;
      prev_key_r   <= prev_key_nxt;
    end
  end

endmodule

// ===== sv/kcl_checker.sv =====
`include "keypad_combination_lock_assert.svh"

module kcl_checker
  import kcl_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input kcl_out_t out_data
);

  // A stalled result stays and holds its value
  `KCL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // Door-open mode and lock release always agree
  `KCL_ASSERT_NOW(a_mode_door, clk, rst_n, out_valid, (out_data.mode == MODE_OPEN) == out_data.lock_release)

  // An unlock clears the alarm and the miss count
  `KCL_ASSERT_NOW(a_unlock_clear, clk, rst_n, out_valid && out_data.event_res == EV_UNLOCKED, out_data.lock_release && !out_data.alarm_on && !out_data.alarm_pin && out_data.misses == 8'd0)

  // Relock events leave the door shut
  `KCL_ASSERT_NOW(a_relock, clk, rst_n, out_valid && (out_data.event_res == EV_LOCKED || out_data.event_res == EV_TIMEOUT), !out_data.lock_release)

  // A raised alarm shows as active
  `KCL_ASSERT_NOW(a_alarm_on, clk, rst_n, out_valid && out_data.event_res == EV_ALARM, out_data.alarm_on)

endmodule

bind keypad_combination_lock kcl_checker u_kcl_checker (.*);
